// ===== design/vrp_pkg.sv =====
// shared types, constants and helpers for the vertex rotate/project block
`default_nettype none
package vrp_pkg;

   localparam int VERT_W   = 16;
   localparam int ROT_W    = 22;   // row sum >>> 12
   localparam int TRN_W    = 33;   // rotated value plus translation
   localparam int MUL_W    = 50;   // projection distance times translated value
   localparam int DIV_BITS = 49;   // quotient bits, one per divider cell
   localparam int DVSR_W   = 32;
   localparam int REM_W    = 33;
   localparam int FIN_W    = 51;   // signed quotient plus screen offset

   localparam logic [47:0] ROW0_RST = 48'h0000_0000_1000;
   localparam logic [47:0] ROW1_RST = 48'h0000_1000_0000;
   localparam logic [47:0] ROW2_RST = 48'h1000_0000_0000;

   typedef enum logic [2:0] {
      CSR_ROW0       = 3'd0,
      CSR_ROW1       = 3'd1,
      CSR_ROW2       = 3'd2,
      CSR_TRANS_X    = 3'd3,
      CSR_TRANS_Y    = 3'd4,
      CSR_TRANS_Z    = 3'd5,
      CSR_PROJ_DIST  = 3'd6,
      CSR_SCREEN_OFS = 3'd7
   } vrp_csr_index_type;

   typedef enum logic {
      CMD_ROTATE  = 1'b0,
      CMD_PROJECT = 1'b1
   } vrp_cmd_type;

   typedef struct packed {
      logic [47:0] row0;
      logic [47:0] row1;
      logic [47:0] row2;
      logic [31:0] trans_x;
      logic [31:0] trans_y;
      logic [31:0] trans_z;
      logic [15:0] proj_dist;
   } vrp_cfg_type;

   // one divider slot: both lanes plus everything the output stage needs
   typedef struct packed {
      logic                 valid;
      logic                 cmd;
      logic                 pos;
      logic                 neg_x;
      logic                 neg_y;
      logic [15:0]          rot_x;
      logic [15:0]          rot_y;
      logic [31:0]          depth;
      logic [DVSR_W-1:0]    dvsr;
      logic [REM_W-1:0]     rem_x;
      logic [REM_W-1:0]     rem_y;
      logic [DIV_BITS-1:0]  num_x;
      logic [DIV_BITS-1:0]  num_y;
   } vrp_div_type;

   function automatic logic [15:0] sat16(input logic signed [FIN_W-1:0] v);
      logic [15:0] r;
      if (v > $signed(51'sd32767)) begin
         r = 16'h7fff;
      end else if (v < -$signed(51'sd32768)) begin
         r = 16'h8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   function automatic logic [31:0] sat32(input logic signed [TRN_W-1:0] v);
      logic [31:0] r;
      if (v[32] != v[31]) begin
         r = v[32] ? 32'h8000_0000 : 32'h7fff_ffff;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== design/vertex_rotate_project.sv =====
// top level: rotate, translate and perspective-project a stream of vertices
// one request per cycle unless the response stalls. the matrix products, row sums,
// translation, projection multiply and magnitude stages come first, then a row of
// 49 divider cells (one quotient bit each for x and y), then the response register.
// the whole row advances together whenever the response register is empty or being
// taken, so a stalled response holds the row. the user, not the block, must see that
// configuration is written through the csr port while no request is in flight.
`default_nettype none
module vertex_rotate_project (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // vert_x 15:0, vert_y 31:16, vert_z 47:32
   input  wire logic        req_tuser,   // cmd
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // out_x 15:0, out_y 31:16, out_z 63:32
   output logic             rsp_tuser,   // in_front
   // configuration writes
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [47:0] csr_wdata
);
   import vrp_pkg::*;

   // configuration registers
   vrp_cfg_type cfg_ff;
   logic [31:0] ofs_ff;

   // pipeline advance: response register free or drained this cycle
   logic        adv;

   vrp_div_type chain [DIV_BITS+1];
   vrp_div_type last;

   // response register
   logic        rsp_valid_ff;
   logic [63:0] rsp_data_ff, rsp_data_in;
   logic        rsp_user_ff, rsp_user_in;

   // final signed quotients plus screen offsets
   logic signed [FIN_W-1:0] qx, qy, fx, fy;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row0      <= ROW0_RST;
         cfg_ff.row1      <= ROW1_RST;
         cfg_ff.row2      <= ROW2_RST;
         cfg_ff.trans_x   <= '0;
         cfg_ff.trans_y   <= '0;
         cfg_ff.trans_z   <= '0;
         cfg_ff.proj_dist <= '0;
         ofs_ff           <= '0;
      end else if (csr_we) begin
         unique case (vrp_csr_index_type'(csr_index))
            CSR_ROW0:       cfg_ff.row0      <= csr_wdata;
            CSR_ROW1:       cfg_ff.row1      <= csr_wdata;
            CSR_ROW2:       cfg_ff.row2      <= csr_wdata;
            CSR_TRANS_X:    cfg_ff.trans_x   <= csr_wdata[31:0];
            CSR_TRANS_Y:    cfg_ff.trans_y   <= csr_wdata[31:0];
            CSR_TRANS_Z:    cfg_ff.trans_z   <= csr_wdata[31:0];
            CSR_PROJ_DIST:  cfg_ff.proj_dist <= csr_wdata[15:0];
            CSR_SCREEN_OFS: ofs_ff           <= csr_wdata[31:0];
            default:        ;
         endcase
      end
   end

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   // products, translation and projection multiply
   vrp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_tvalid),
      .in_cmd   (req_tuser),
      .in_vert  (req_tdata),
      .cfg      (cfg_ff),
      .div_out  (chain[0])
   );

   // divider row, most significant quotient bit first
   for (genvar i = 0; i < DIV_BITS; i++) begin : g_cell
      vrp_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .cell_in  (chain[i]),
         .cell_out (chain[i+1])
      );
   end

   assign last = chain[DIV_BITS];

   // quotient truncates toward zero: divide magnitudes, then restore the sign
   always_comb begin
      qx = last.neg_x ? -$signed({2'b00, last.num_x}) : $signed({2'b00, last.num_x});
      qy = last.neg_y ? -$signed({2'b00, last.num_y}) : $signed({2'b00, last.num_y});
      fx = qx + FIN_W'($signed(ofs_ff[15:0]));
      fy = qy + FIN_W'($signed(ofs_ff[31:16]));
      unique case (vrp_cmd_type'(last.cmd))
         CMD_ROTATE: begin
            rsp_data_in = {last.depth, last.rot_y, last.rot_x};
            rsp_user_in = 1'b1;
         end
         CMD_PROJECT: begin
            // depth not positive: screen coordinates forced to zero
            rsp_data_in = last.pos ? {last.depth, sat16(fy), sat16(fx)}
                                   : {last.depth, 32'h0};
            rsp_user_in = last.pos;
         end
         default: begin
            rsp_data_in = '0;
            rsp_user_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= last.valid;
         rsp_data_ff  <= rsp_data_in;
         rsp_user_ff  <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
`default_nettype wire

// ===== design/vrp_front.sv =====
// matrix multiply, translate and projection multiply ahead of the divider row
`default_nettype none
module vrp_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                adv,
   input  wire logic                in_valid,
   input  wire logic                in_cmd,
   input  wire logic [47:0]         in_vert,
   input  wire vrp_pkg::vrp_cfg_type cfg,
   output vrp_pkg::vrp_div_type     div_out
);
   import vrp_pkg::*;

   logic [47:0] rows [3];

   // stage 1: nine products
   logic signed [31:0] prod_in [3][3];
   logic signed [31:0] prod_ff [3][3];
   logic               v1_ff, c1_ff;
   // stage 2: row sums shifted down
   logic signed [ROT_W-1:0] rot_in [3];
   logic signed [ROT_W-1:0] rot_ff [3];
   logic                    v2_ff, c2_ff;
   // stage 3: translate and rotate saturation
   logic signed [TRN_W-1:0] trn_in [3];
   logic signed [TRN_W-1:0] trn_ff [3];
   logic [15:0]             rs_in [3];
   logic [15:0]             rs_ff [3];
   logic                    v3_ff, c3_ff;
   // stage 4: projection multiply
   logic signed [MUL_W-1:0] mul_in [2];
   logic signed [MUL_W-1:0] mul_ff [2];
   logic [15:0]             rs4_ff [3];
   logic [31:0]             dep_ff;
   logic [DVSR_W-1:0]       z4_ff;
   logic                    pos_ff;
   logic                    v4_ff, c4_ff;
   // stage 5: magnitudes into divider format
   vrp_div_type             div_in, div_ff;
   logic [MUL_W-1:0]        mag_x, mag_y;

   assign rows[0] = cfg.row0;
   assign rows[1] = cfg.row1;
   assign rows[2] = cfg.row2;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[r][c] = $signed(rows[r][16*c +: 16]) * $signed(in_vert[16*c +: 16]);
         end
      end
   end

   always_comb begin
      logic signed [33:0] s;
      for (int r = 0; r < 3; r++) begin
         s = 34'(prod_ff[r][0]) + 34'(prod_ff[r][1]) + 34'(prod_ff[r][2]);
         rot_in[r] = s[33:12];
      end
   end

   always_comb begin
      trn_in[0] = TRN_W'(rot_ff[0]) + TRN_W'($signed(cfg.trans_x));
      trn_in[1] = TRN_W'(rot_ff[1]) + TRN_W'($signed(cfg.trans_y));
      trn_in[2] = TRN_W'(rot_ff[2]) + TRN_W'($signed(cfg.trans_z));
      for (int r = 0; r < 3; r++) begin
         rs_in[r] = sat16(FIN_W'(rot_ff[r]));
      end
   end

   always_comb begin
      mul_in[0] = $signed({1'b0, cfg.proj_dist}) * trn_ff[0];
      mul_in[1] = $signed({1'b0, cfg.proj_dist}) * trn_ff[1];
   end

   always_comb begin
      mag_x = mul_ff[0][MUL_W-1] ? MUL_W'(-mul_ff[0]) : MUL_W'(mul_ff[0]);
      mag_y = mul_ff[1][MUL_W-1] ? MUL_W'(-mul_ff[1]) : MUL_W'(mul_ff[1]);
      div_in.valid = v4_ff;
      div_in.cmd   = c4_ff;
      div_in.pos   = pos_ff;
      div_in.neg_x = mul_ff[0][MUL_W-1];
      div_in.neg_y = mul_ff[1][MUL_W-1];
      div_in.rot_x = rs4_ff[0];
      div_in.rot_y = rs4_ff[1];
      div_in.depth = (c4_ff == CMD_PROJECT) ? dep_ff : {{16{rs4_ff[2][15]}}, rs4_ff[2]};
      div_in.dvsr  = pos_ff ? z4_ff : DVSR_W'(1);
      div_in.rem_x = '0;
      div_in.rem_y = '0;
      div_in.num_x = mag_x[DIV_BITS-1:0];
      div_in.num_y = mag_y[DIV_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         div_ff.valid <= 1'b0;
      end else if (adv) begin
         v1_ff   <= in_valid;
         c1_ff   <= in_cmd;
         prod_ff <= prod_in;
         v2_ff   <= v1_ff;
         c2_ff   <= c1_ff;
         rot_ff  <= rot_in;
         v3_ff   <= v2_ff;
         c3_ff   <= c2_ff;
         trn_ff  <= trn_in;
         rs_ff   <= rs_in;
         v4_ff   <= v3_ff;
         c4_ff   <= c3_ff;
         mul_ff  <= mul_in;
         rs4_ff  <= rs_ff;
         dep_ff  <= sat32(trn_ff[2]);
         z4_ff   <= trn_ff[2][DVSR_W-1:0];
         pos_ff  <= !trn_ff[2][TRN_W-1] && (trn_ff[2] != '0);
         div_ff  <= div_in;
      end
   end

   assign div_out = div_ff;

endmodule
`default_nettype wire

// ===== design/vrp_div_cell.sv =====
// one restoring-divide cell: one quotient bit per lane, handed to the next cell
`default_nettype none
module vrp_div_cell (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                adv,
   input  wire vrp_pkg::vrp_div_type cell_in,
   output vrp_pkg::vrp_div_type     cell_out
);
   import vrp_pkg::*;

   vrp_div_type      cell_in_nx, cell_ff;
   logic [REM_W-1:0] sh_x, sh_y;
   logic [REM_W:0]   df_x, df_y;

   always_comb begin
      cell_in_nx = cell_in;
      sh_x = {cell_in.rem_x[REM_W-2:0], cell_in.num_x[DIV_BITS-1]};
      sh_y = {cell_in.rem_y[REM_W-2:0], cell_in.num_y[DIV_BITS-1]};
      df_x = {1'b0, sh_x} - {2'b0, cell_in.dvsr};
      df_y = {1'b0, sh_y} - {2'b0, cell_in.dvsr};
      cell_in_nx.rem_x = df_x[REM_W] ? sh_x : df_x[REM_W-1:0];
      cell_in_nx.rem_y = df_y[REM_W] ? sh_y : df_y[REM_W-1:0];
      cell_in_nx.num_x = {cell_in.num_x[DIV_BITS-2:0], !df_x[REM_W]};
      cell_in_nx.num_y = {cell_in.num_y[DIV_BITS-2:0], !df_y[REM_W]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (adv) begin
         cell_ff <= cell_in_nx;
      end
   end

   assign cell_out = cell_ff;

endmodule
`default_nettype wire

// ===== design/vrp_checker.sv =====
// port-level checks for the vertex rotate/project block, bound to the top level
`default_nettype none
module vrp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [63:0] rsp_tdata,
   input wire logic        rsp_tuser,
   input wire logic        req_tready
);

   // a held response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // nothing comes out right after reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid after reset");

   // a vertex behind the viewer has zero screen coordinates
   a_behind_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[31:0] == 32'h0)
      else $error("screen coordinates set for a vertex behind the viewer");

   // a vertex behind the viewer has depth zero or negative
   a_behind_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[63] || rsp_tdata[63:32] == 32'h0)
      else $error("positive depth flagged as behind the viewer");

   // the request side keeps moving while the response is taken
   a_ready_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("request stalled while response side is ready");

endmodule

bind vertex_rotate_project vrp_checker u_vrp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .req_tready (req_tready)
);
`default_nettype wire
